[src/psq_pkg.sv]
`timescale 1ns / 1ps
package psq_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_POLL   = 2'd1;
    localparam logic [1:0] ACT_TAKE   = 2'd2;
    localparam logic [1:0] ACT_FINISH = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOT_DUE  = 3'd4;
    localparam logic [2:0] ST_RETIRED  = 3'd5;
    localparam logic [2:0] ST_BAD_SLOT = 3'd6;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now;
        logic [7:0]  task_id;
        logic [31:0] start_offset;
        logic [31:0] run_period;
        logic        permanent;
        logic [31:0] run_count;
        logic [15:0] busy_time;
        logic [3:0]  finish_slot;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        available;
        logic [7:0]  out_task;
        logic [3:0]  out_slot;
        logic [15:0] out_busy_time;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       scan_clr;
        logic       scan_inc;
        logic       add_wr;
        logic       ord_rd_prev;
        logic       due_rd_ord;
        logic       ins_shift;
        logic       ins_put;
        logic       ord_rd_head;
        logic       head_rd;
        logic       pop;
        logic       fin_rd;
        logic       fin_upd;
        logic       div_start;
        logic       fin_wr;
        logic       retire;
        logic       res_load;
        logic [2:0] res_status;
        logic       res_avail;
        logic       res_take;
        logic       res_slot;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       reject;
        logic       q_empty;
        logic       scan_free;
        logic       scan_last;
        logic       i_zero;
        logic       due_gt_t;
        logic       now_lt_due;
        logic       due_lt_now;
        logic       bad_slot;
        logic       runs_one;
        logic       next_lt_now;
        logic       div_done;
    } sts_t;

endpackage

[src/psq_ram.sv]
`timescale 1ns / 1ps
module psq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[src/psq_rem.sv]
`timescale 1ns / 1ps
module psq_rem (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] rem
);
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] sh_reg, sh_next;
    logic [31:0] div_reg, div_next;
    logic [32:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        div_next  = div_reg;
        trial     = {rem_reg[31:0], sh_reg[31]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            rem_next  = 33'd0;
            sh_next   = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = (trial >= {1'b0, div_reg}) ? trial - {1'b0, div_reg} : trial;
            sh_next  = {sh_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        div_reg <= div_next;
    end

    assign done = !busy_reg;
    assign rem  = rem_reg[31:0];
endmodule

[src/psq_datapath.sv]
`timescale 1ns / 1ps
module psq_datapath
    import psq_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp
);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    req_t              in_reg;
    logic [SLOT_W-1:0] slot_reg, scan_reg, head_reg;
    logic [CNT_W-1:0]  count_reg, i_reg;
    logic [31:0]       t_reg, next_reg, per_reg;
    logic              use_cat_reg;
    logic [SLOTS-1:0]  used_reg, taken_reg;
    rsp_t              res_reg;

    logic [31:0]       due_q, per_q, runs_q;
    logic [23:0]       tb_q;
    logic [SLOT_W-1:0] ord_q, fs_idx;
    logic [31:0]       next_w, cat_w, fin_val, rem_w;
    logic              rem_done;

    logic              due_we, due_re, runs_we, ord_we, ord_re;
    logic [SLOT_W-1:0] due_waddr, due_raddr, runs_waddr, ord_waddr, ord_raddr;
    logic [31:0]       due_wdata, runs_wdata;
    logic [SLOT_W-1:0] ord_wdata;

    function automatic logic [SLOT_W-1:0] wrap(input logic [SLOT_W-1:0] b,
                                               input logic [CNT_W-1:0] off);
        logic [SLOT_W:0] sum;
        sum = (SLOT_W+1)'(b) + (SLOT_W+1)'(off);
        if (sum >= (SLOT_W+1)'(SLOTS))
        begin
            sum = sum - (SLOT_W+1)'(SLOTS);
        end
        return sum[SLOT_W-1:0];
    endfunction

    assign fs_idx  = SLOT_W'(in_reg.finish_slot);
    assign next_w  = due_q + per_q;
    assign cat_w   = (rem_w == 32'd0) ? in_reg.now : in_reg.now + (per_reg - rem_w);
    assign fin_val = use_cat_reg ? cat_w : next_reg;

    assign due_we    = cmd.add_wr || cmd.fin_wr;
    assign due_waddr = cmd.add_wr ? scan_reg : slot_reg;
    assign due_wdata = cmd.add_wr ? in_reg.now + in_reg.start_offset : fin_val;
    assign due_re    = cmd.fin_rd || cmd.due_rd_ord || cmd.head_rd;
    assign due_raddr = cmd.fin_rd ? fs_idx : ord_q;

    assign runs_we    = cmd.add_wr || (cmd.fin_upd && runs_q > 32'd1);
    assign runs_waddr = cmd.add_wr ? scan_reg : slot_reg;
    assign runs_wdata = cmd.add_wr ? (in_reg.permanent ? 32'd0 : in_reg.run_count)
                                   : runs_q - 32'd1;

    assign ord_we    = cmd.ins_shift || cmd.ins_put;
    assign ord_waddr = wrap(head_reg, i_reg);
    assign ord_wdata = cmd.ins_put ? slot_reg : ord_q;
    assign ord_re    = cmd.ord_rd_prev || cmd.ord_rd_head;
    assign ord_raddr = cmd.ord_rd_head ? head_reg : wrap(head_reg, i_reg - CNT_W'(1));

    psq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_due (
        .clk(clk), .we(due_we), .waddr(due_waddr), .wdata(due_wdata),
        .re(due_re), .raddr(due_raddr), .rdata(due_q)
    );

    psq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_per (
        .clk(clk), .we(cmd.add_wr), .waddr(scan_reg), .wdata(in_reg.run_period),
        .re(cmd.fin_rd), .raddr(fs_idx), .rdata(per_q)
    );

    psq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_runs (
        .clk(clk), .we(runs_we), .waddr(runs_waddr), .wdata(runs_wdata),
        .re(cmd.fin_rd), .raddr(fs_idx), .rdata(runs_q)
    );

    psq_ram #(.WIDTH(24), .DEPTH(SLOTS)) u_tb (
        .clk(clk), .we(cmd.add_wr), .waddr(scan_reg),
        .wdata({in_reg.task_id, in_reg.busy_time}),
        .re(cmd.head_rd), .raddr(ord_q), .rdata(tb_q)
    );

    psq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_ord (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .re(ord_re), .raddr(ord_raddr), .rdata(ord_q)
    );

    psq_rem u_rem (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .dividend(in_reg.now - next_w), .divisor(per_q),
        .done(rem_done), .rem(rem_w)
    );

    always_comb
    begin
        sts.action      = in_reg.action;
        sts.reject      = (in_reg.task_id == 8'd0) || (in_reg.run_period == 32'd0)
                          || (!in_reg.permanent && in_reg.run_count == 32'd0);
        sts.q_empty     = (count_reg == CNT_W'(0));
        sts.scan_free   = !used_reg[scan_reg];
        sts.scan_last   = (scan_reg == SLOT_W'(SLOTS - 1));
        sts.i_zero      = (i_reg == CNT_W'(0));
        sts.due_gt_t    = (due_q > t_reg);
        sts.now_lt_due  = (in_reg.now < due_q);
        sts.due_lt_now  = (due_q < in_reg.now);
        sts.bad_slot    = ({28'd0, in_reg.finish_slot} >= 32'(SLOTS)) || !taken_reg[fs_idx];
        sts.runs_one    = (runs_q == 32'd1);
        sts.next_lt_now = (next_w < in_reg.now) && (per_q != 32'd0);
        sts.div_done    = rem_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            taken_reg <= '0;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            if (cmd.add_wr)
            begin
                used_reg[scan_reg]  <= 1'b1;
                taken_reg[scan_reg] <= 1'b0;
            end
            if (cmd.pop)
            begin
                taken_reg[ord_q] <= 1'b1;
                head_reg         <= wrap(head_reg, CNT_W'(1));
                count_reg        <= count_reg - CNT_W'(1);
            end
            if (cmd.fin_upd)
            begin
                taken_reg[slot_reg] <= 1'b0;
            end
            if (cmd.retire)
            begin
                taken_reg[slot_reg] <= 1'b0;
                used_reg[slot_reg]  <= 1'b0;
            end
            if (cmd.ins_put)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= req;
        end
        if (cmd.scan_clr)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + SLOT_W'(1);
        end
        if (cmd.add_wr)
        begin
            slot_reg <= scan_reg;
            t_reg    <= in_reg.now + in_reg.start_offset;
            i_reg    <= count_reg;
        end
        if (cmd.fin_rd)
        begin
            slot_reg <= fs_idx;
        end
        if (cmd.pop)
        begin
            slot_reg <= ord_q;
        end
        if (cmd.fin_upd)
        begin
            next_reg    <= next_w;
            per_reg     <= per_q;
            use_cat_reg <= sts.next_lt_now;
        end
        if (cmd.fin_wr)
        begin
            t_reg <= fin_val;
            i_reg <= count_reg;
        end
        if (cmd.ins_shift)
        begin
            i_reg <= i_reg - CNT_W'(1);
        end
        if (cmd.res_load)
        begin
            res_reg.status        <= cmd.res_status;
            res_reg.available     <= cmd.res_avail;
            res_reg.out_task      <= cmd.res_take ? tb_q[23:16] : 8'd0;
            res_reg.out_busy_time <= cmd.res_take ? tb_q[15:0] : 16'd0;
            res_reg.out_slot      <= cmd.res_slot ? 4'(slot_reg) : 4'd0;
        end
    end

    assign rsp = res_reg;
endmodule

[src/psq_ctrl.sv]
`timescale 1ns / 1ps
module psq_ctrl
    import psq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    output logic rsp_valid,
    input  logic rsp_stall,
    input  sts_t sts,
    output cmd_t cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_SCAN, S_INS_CHK, S_INS_A, S_INS_B,
        S_Q_A, S_Q_B, S_F_A, S_F_WR, S_DIV, S_RES
    } state_t;

    typedef struct packed {
        logic [2:0] status;
        logic       avail;
        logic       take;
        logic       slot;
    } pend_t;

    state_t state_reg, state_next;
    pend_t  pend_reg, pend_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                pend_next = '{status: ST_OK, avail: 1'b0, take: 1'b0, slot: 1'b0};
                case (sts.action)
                    ACT_ADD:
                    begin
                        if (sts.reject)
                        begin
                            pend_next.status = ST_REJECTED;
                            state_next       = S_RES;
                        end
                        else
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_SCAN;
                        end
                    end
                    ACT_POLL, ACT_TAKE:
                    begin
                        if (sts.q_empty)
                        begin
                            pend_next.status = ST_EMPTY;
                            state_next       = S_RES;
                        end
                        else
                        begin
                            cmd.ord_rd_head = 1'b1;
                            state_next      = S_Q_A;
                        end
                    end
                    default:
                    begin
                        if (sts.bad_slot)
                        begin
                            pend_next.status = ST_BAD_SLOT;
                            state_next       = S_RES;
                        end
                        else
                        begin
                            cmd.fin_rd = 1'b1;
                            state_next = S_F_A;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_free)
                begin
                    cmd.add_wr     = 1'b1;
                    pend_next.slot = 1'b1;
                    state_next     = S_INS_CHK;
                end
                else if (sts.scan_last)
                begin
                    pend_next.status = ST_FULL;
                    state_next       = S_RES;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            S_INS_CHK:
            begin
                if (sts.i_zero)
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = S_RES;
                end
                else
                begin
                    cmd.ord_rd_prev = 1'b1;
                    state_next      = S_INS_A;
                end
            end
            S_INS_A:
            begin
                cmd.due_rd_ord = 1'b1;
                state_next     = S_INS_B;
            end
            S_INS_B:
            begin
                if (sts.due_gt_t)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = S_INS_CHK;
                end
                else
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = S_RES;
                end
            end
            S_Q_A:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_Q_B;
            end
            S_Q_B:
            begin
                state_next = S_RES;
                if (sts.action == ACT_POLL)
                begin
                    pend_next.avail = sts.due_lt_now;
                end
                else if (sts.now_lt_due)
                begin
                    pend_next.status = ST_NOT_DUE;
                end
                else
                begin
                    cmd.pop        = 1'b1;
                    pend_next.take = 1'b1;
                    pend_next.slot = 1'b1;
                end
            end
            S_F_A:
            begin
                if (sts.runs_one)
                begin
                    cmd.retire       = 1'b1;
                    pend_next.status = ST_RETIRED;
                    state_next       = S_RES;
                end
                else
                begin
                    cmd.fin_upd = 1'b1;
                    if (sts.next_lt_now)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        state_next = S_F_WR;
                    end
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_F_WR;
                end
            end
            S_F_WR:
            begin
                cmd.fin_wr = 1'b1;
                state_next = S_INS_CHK;
            end
            S_RES:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.res_status = pend_reg.status;
        cmd.res_avail  = pend_reg.avail;
        cmd.res_take   = pend_reg.take;
        cmd.res_slot   = pend_reg.slot;
        out_valid_next = cmd.res_load || (out_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
endmodule

[src/periodic_service_timer_queue.sv]
`timescale 1ns / 1ps
// Periodic service timer queue.
// req beat (req_valid/req_stall, payload req) carries one action: add, poll,
// take or finish. Every beat yields exactly one rsp beat (rsp_valid/rsp_stall).
// One action is in work at a time; req_stall is high from acceptance until the
// result is moved into the output register.
// Work per action, done by a walk of the order RAM one entry at a time:
//   poll, take: read the head entry; rejected add or bad finish: no RAM walk;
//   retire: read and free the slot; full add: scan of all SLOTS slots.
//   add: lowest-free-slot scan (one slot tried at a time, up to SLOTS)
//        + a walk from the tail moving each queued entry due later behind
//        the new one, stopping on an entry not due later or at the head.
//   finish: the same walk for the slot's next due time, plus a catch-up
//   remainder when the next due time has fallen behind now.
// The output register decouples the sides: a new req beat is taken while
// the last result waits under rsp_stall; the next result waits in turn.
// Reset clears the queue, the slot flags and rsp_valid, and drops req_stall;
// per-slot stores are not cleared and need no sweep.
module periodic_service_timer_queue
    import psq_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);
    cmd_t cmd;
    sts_t sts;

    psq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .sts(sts), .cmd(cmd)
    );

    psq_datapath #(.SLOTS(SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .req(req), .cmd(cmd), .sts(sts), .rsp(rsp)
    );
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
module tb;
    import psq_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int RAND_ITEMS = 500;
    localparam int IDLE_LIMIT = 5000;

    class timer_queue_board;
        logic [31:0] due[NSLOT];
        logic [31:0] per[NSLOT];
        logic [31:0] runs[NSLOT];
        logic [7:0]  tid[NSLOT];
        logic [15:0] busy[NSLOT];
        bit          used[NSLOT];
        bit          taken[NSLOT];
        int          order[$];
        rsp_t        pending[$];
        int          errors;

        function void enqueue(int s);
            int pos;
            pos = 0;
            while (pos < order.size() && due[order[pos]] <= due[s])
                pos++;
            order.insert(pos, s);
        endfunction

        function void note_req(req_t r);
            rsp_t        o;
            int          s;
            logic [31:0] nxt;
            logic [63:0] gap;
            logic [63:0] k;
            o = '0;
            o.status = ST_OK;
            case (r.action)
                ACT_ADD:
                begin
                    if (r.task_id == 0 || r.run_period == 0 ||
                        (!r.permanent && r.run_count == 0))
                        o.status = ST_REJECTED;
                    else
                    begin
                        s = 0;
                        while (s < NSLOT && used[s])
                            s++;
                        if (s >= NSLOT)
                            o.status = ST_FULL;
                        else
                        begin
                            due[s] = r.now + r.start_offset;
                            per[s] = r.run_period;
                            runs[s] = r.permanent ? 32'd0 : r.run_count;
                            tid[s] = r.task_id;
                            busy[s] = r.busy_time;
                            used[s] = 1;
                            taken[s] = 0;
                            enqueue(s);
                            o.out_slot = s[3:0];
                        end
                    end
                end
                ACT_POLL:
                begin
                    if (order.size() == 0)
                        o.status = ST_EMPTY;
                    else
                        o.available = due[order[0]] < r.now;
                end
                ACT_TAKE:
                begin
                    if (order.size() == 0)
                        o.status = ST_EMPTY;
                    else if (r.now < due[order[0]])
                        o.status = ST_NOT_DUE;
                    else
                    begin
                        s = order.pop_front();
                        taken[s] = 1;
                        o.out_task = tid[s];
                        o.out_slot = s[3:0];
                        o.out_busy_time = busy[s];
                    end
                end
                default:
                begin
                    s = r.finish_slot;
                    if (s >= NSLOT || !taken[s])
                        o.status = ST_BAD_SLOT;
                    else
                    begin
                        taken[s] = 0;
                        if (runs[s] == 1)
                        begin
                            used[s] = 0;
                            o.status = ST_RETIRED;
                        end
                        else
                        begin
                            nxt = due[s] + per[s];
                            if (runs[s] > 1)
                                runs[s]--;
                            if (nxt < r.now)
                            begin
                                gap = {32'd0, r.now - nxt};
                                k = (gap + per[s] - 1) / per[s];
                                nxt = 32'({32'd0, nxt} + k * per[s]);
                            end
                            due[s] = nxt;
                            enqueue(s);
                        end
                    end
                end
            endcase
            pending.push_back(o);
        endfunction

        function void field_diff(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_rsp(rsp_t a);
            rsp_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none actual %p", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            field_diff("status", e.status, a.status);
            field_diff("available", e.available, a.available);
            field_diff("out_task", e.out_task, a.out_task);
            field_diff("out_slot", e.out_slot, a.out_slot);
            field_diff("out_busy_time", e.out_busy_time, a.out_busy_time);
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic req_valid = 0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 0;
    rsp_t rsp;

    timer_queue_board sb = new();
    logic [31:0] cur_now = 0;
    int idle_cycles = 0;
    int stall_mode = 0;
    int stall_left = 0;

    periodic_service_timer_queue DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall && rst_n)
            sb.check_rsp(rsp);
        if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(5, 60);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            default: rsp_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    task automatic send(req_t r);
        req_valid <= 1;
        req <= r;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_req(r);
    endtask

    function automatic req_t mk(logic [1:0] act, logic [31:0] t);
        req_t r;
        r = '0;
        r.action = act;
        r.now = t;
        r.task_id = 8'($urandom_range(1, 255));
        r.run_period = $urandom_range(1, 100);
        r.run_count = $urandom_range(1, 3);
        r.busy_time = 16'($urandom);
        return r;
    endfunction

    function automatic int taken_slot();
        int c[$];
        for (int i = 0; i < NSLOT; i++)
            if (sb.taken[i])
                c.push_back(i);
        if (c.size() == 0)
            return -1;
        return c[$urandom_range(0, c.size() - 1)];
    endfunction

    function automatic req_t rand_item();
        req_t r;
        int pick;
        int ts;
        logic [31:0] hd;
        cur_now = cur_now + $urandom_range(0, 40);
        pick = $urandom_range(0, 99);
        ts = taken_slot();
        hd = sb.order.size() ? sb.due[sb.order[0]] : cur_now;
        if (pick < 30)
        begin
            r = mk(ACT_ADD, cur_now);
            r.start_offset = $urandom_range(0, 200);
            r.permanent = $urandom_range(0, 3) == 0;
            if ($urandom_range(0, 9) == 0) r.start_offset = $urandom;
            if ($urandom_range(0, 9) == 0) r.run_period = $urandom;
            if ($urandom_range(0, 9) == 0) r.run_count = $urandom;
            if ($urandom_range(0, 19) == 0) r.task_id = 0;
            if ($urandom_range(0, 19) == 0) r.run_period = 0;
            if ($urandom_range(0, 19) == 0) r.run_count = 0;
            if ($urandom_range(0, 19) == 0) r.now = $urandom;
        end
        else if (pick < 40)
        begin
            r = mk(ACT_POLL, $urandom_range(0, 2) ? hd + $urandom_range(0, 2) - 1 : $urandom);
        end
        else if (pick < 70)
        begin
            r = mk(ACT_TAKE, hd + $urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) r.now = hd - 1;
            if ($urandom_range(0, 19) == 0) r.now = $urandom;
        end
        else
        begin
            r = mk(ACT_FINISH, cur_now);
            r.finish_slot = 4'((ts >= 0 && $urandom_range(0, 9)) ? ts : $urandom_range(0, 15));
            if ($urandom_range(0, 4) == 0) r.now = cur_now + $urandom_range(0, 5000);
            if ($urandom_range(0, 19) == 0) r.now = $urandom;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            r.start_offset = $urandom;
            r.run_count = r.run_count | ($urandom & 32'hffff_fff0);
        end
        return r;
    endfunction

    initial
    begin
        req_t r;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // rejects, empty queue, bad finish
        r = mk(ACT_ADD, 0); r.task_id = 0; send(r);
        r = mk(ACT_ADD, 0); r.run_period = 0; send(r);
        r = mk(ACT_ADD, 0); r.permanent = 0; r.run_count = 0; send(r);
        send(mk(ACT_POLL, 32'hffff_ffff));
        send(mk(ACT_TAKE, 32'hffff_ffff));
        r = mk(ACT_FINISH, 0); r.finish_slot = 4'hf; send(r);
        // wrapped due time, max fields
        r = mk(ACT_ADD, 32'hffff_fff0); r.start_offset = 32'h20; r.task_id = 8'hff;
        r.run_period = 32'hffff_ffff; r.permanent = 1; r.run_count = 32'hffff_ffff;
        r.busy_time = 16'hffff; r.finish_slot = 4'hf; send(r);
        send(mk(ACT_POLL, 32'h10));
        send(mk(ACT_POLL, 32'h11));
        send(mk(ACT_TAKE, 32'h0f));
        send(mk(ACT_TAKE, 32'h10));
        r = mk(ACT_FINISH, 32'h10); r.finish_slot = 0; send(r);
        // fill the table, then one more
        for (int i = 0; i < NSLOT; i++)
        begin
            r = mk(ACT_ADD, 100); r.start_offset = $urandom_range(0, 20);
            r.run_count = 1 + (i % 2); send(r);
        end
        // retire and count down, catch-up on a late finish
        for (int i = 0; i < 3; i++)
        begin
            send(mk(ACT_TAKE, 120));
            r = mk(ACT_FINISH, 32'h0010_0000);
            r.finish_slot = 4'(sb.order.size() ? taken_slot() : 0);
            send(r);
        end
        cur_now = 32'h0010_0000;

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            send(rand_item());
            if ($urandom_range(0, 5) == 0)
            begin
                req_valid <= 0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        req_valid <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
